FILE: hw/rtl/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg: shared types, codes and helpers of the line follow steering unit
// field widths, command / vertex / status codes, register indexes, speed clamp
// ----------------------------------------------------------------------------
`default_nettype none

package lfpd_pkg;

    // field widths
    localparam int CMD_W    = 2;
    localparam int POS_W    = 13;
    localparam int READ_W   = 12;
    localparam int SPEED_W  = 12;
    localparam int VTX_W    = 3;
    localparam int ADDR_W   = 10;
    localparam int GAIN_W   = 16;
    localparam int DEST_W   = 16;
    localparam int CORR_W   = 22;
    localparam int STAT_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // stream packing widths
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 5;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;

    // default distance covered by one address mark
    localparam int PARK_STEP_DEFAULT = 64;

    // drive commands
    localparam logic [CMD_W-1:0] CMD_FORWARD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RIGHT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LEFT    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ADDRESS = 2'd3;

    // vertex types
    localparam logic [VTX_W-1:0] VTX_PLUS        = 3'd0;
    localparam logic [VTX_W-1:0] VTX_TEE         = 3'd1;
    localparam logic [VTX_W-1:0] VTX_LEFT_TEE    = 3'd2;
    localparam logic [VTX_W-1:0] VTX_RIGHT_TEE   = 3'd3;
    localparam logic [VTX_W-1:0] VTX_LEFT_NINETY = 3'd4;
    localparam logic [VTX_W-1:0] VTX_RIGHT_NINETY = 3'd5;

    // result status
    localparam logic [STAT_W-1:0] STAT_FOLLOW    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_CROSS     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_RIGHT     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_LEFT      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMERGENCY = 3'd4;
    localparam logic [STAT_W-1:0] STAT_PARK      = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_POS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CORRECTION  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_CEILING   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_FLOOR     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_ADDRESS    = 3'd7;

    typedef struct packed {
        logic signed [GAIN_W-1:0] position_gain;
        logic signed [GAIN_W-1:0] delta_gain;
        logic [READ_W-1:0]        black_threshold;
        logic [POS_W-1:0]         reference_position;
        logic [SPEED_W-1:0]       max_correction;
        logic [SPEED_W-1:0]       speed_ceiling;
        logic [SPEED_W-1:0]       speed_floor;
        logic [DEST_W-1:0]        destination_address;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   previous_position;
        logic [READ_W-1:0]  left_reading;
        logic [READ_W-1:0]  right_reading;
        logic [SPEED_W-1:0] base_speed;
        logic [VTX_W-1:0]   vertex_type;
        logic [ADDR_W-1:0]  address_count;
    } sample_t;

    typedef struct packed {
        logic signed [CORR_W-1:0] correction;
        logic [SPEED_W-1:0]       left_speed;
        logic [SPEED_W-1:0]       right_speed;
        logic [STAT_W-1:0]        status;
    } result_t;

    // clamp a raw wheel speed to max first, then to min (min wins)
    function automatic logic [SPEED_W-1:0] clamp_speed(
        input logic signed [CORR_W:0] raw,
        input logic [SPEED_W-1:0]     hi,
        input logic [SPEED_W-1:0]     lo
    );
        logic signed [CORR_W:0] t;
        t = raw;
        if (t > $signed({{(CORR_W+1-SPEED_W){1'b0}}, hi})) begin
            t = $signed({{(CORR_W+1-SPEED_W){1'b0}}, hi});
        end
        if (t < $signed({{(CORR_W+1-SPEED_W){1'b0}}, lo})) begin
            t = $signed({{(CORR_W+1-SPEED_W){1'b0}}, lo});
        end
        return t[SPEED_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/line_follow_pd_steering_unit.sv
// ----------------------------------------------------------------------------
// line_follow_pd_steering_unit: pd line following steering, differential drive
// one control sample in, one steering result out (correction, wheels, status)
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake             payload
//   s_       in   s_tvalid / s_tready   control sample (tdata, tuser)
//   m_       out  m_tvalid / m_tready   steering result (tdata, tuser)
//   cfg_     in   cfg_valid / cfg_ready register index and write data
//
// one request per cycle sustained while m_tready keeps the output moving; a sample
// enters the input register when accepted and its result moves into the output
// register when that register is free or being read, which raises m_tvalid
// the wheel state updates as a sample moves into the output register
// synchronous active-low reset clears valids and wheels and resets the register file to its defaults
// the input stalls only while both registers are full and the result is held;
// cfg_ready is always high
//
`default_nettype none

module line_follow_pd_steering_unit #(
    parameter int PARK_STEP = lfpd_pkg::PARK_STEP_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // sample: position, previous_position, left_reading, right_reading,
    // base_speed, address_count
    input  wire logic [lfpd_pkg::S_TDATA_W-1:0]     s_tdata,
    // sample: command, vertex_type
    input  wire logic [lfpd_pkg::S_TUSER_W-1:0]     s_tuser,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // result: correction, left_speed, right_speed, zero pad
    output logic [lfpd_pkg::M_TDATA_W-1:0]          m_tdata,
    // result: status
    output logic [lfpd_pkg::M_TUSER_W-1:0]          m_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lfpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lfpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lfpd_pkg::*;

    cfg_t               cfg;
    sample_t            s_sample;
    sample_t            in_reg;
    logic               in_vld_reg;
    logic               in_vld_next;
    result_t            res;
    result_t            out_reg;
    logic               out_vld_reg;
    logic               out_vld_next;
    logic [SPEED_W-1:0] left_wheel_reg;
    logic [SPEED_W-1:0] right_wheel_reg;
    logic               advance;
    logic               s_take;

    // register file
    assign cfg_ready = 1'b1;

    lfpd_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // unpack the sample
    always_comb begin
        s_sample.command           = s_tuser[1:0];
        s_sample.vertex_type       = s_tuser[4:2];
        s_sample.position          = s_tdata[12:0];
        s_sample.previous_position = s_tdata[25:13];
        s_sample.left_reading      = s_tdata[37:26];
        s_sample.right_reading     = s_tdata[49:38];
        s_sample.base_speed        = s_tdata[61:50];
        s_sample.address_count     = s_tdata[71:62];
    end

    // flow control
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    assign in_vld_next  = s_take ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);

    // steering logic
    lfpd_datapath #(
        .PARK_STEP (PARK_STEP)
    ) u_datapath (
        .din         (in_reg),
        .cfg         (cfg),
        .wheel_left  (left_wheel_reg),
        .wheel_right (right_wheel_reg),
        .dout        (res)
    );

    // valids and wheel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            left_wheel_reg  <= '0;
            right_wheel_reg <= '0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance) begin
                left_wheel_reg  <= res.left_speed;
                right_wheel_reg <= res.right_speed;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_reg <= s_sample;
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, out_reg.right_speed, out_reg.left_speed, out_reg.correction};
    assign m_tuser  = out_reg.status;

    // wheel state moves only with a sample
    a_wheel_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(left_wheel_reg) && $stable(right_wheel_reg))
        else $error("wheel state changed without a sample");

    // emergency stop zeroes wheels and correction
    a_emergency: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_reg.status == STAT_EMERGENCY)
        |-> (out_reg.correction == '0 && out_reg.left_speed == '0
             && out_reg.right_speed == '0))
        else $error("emergency result with nonzero drive");

    // park reports no correction and keeps the wheels
    a_park: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res.status == STAT_PARK)
        |-> (res.correction == '0 && res.left_speed == left_wheel_reg
             && res.right_speed == right_wheel_reg))
        else $error("park result changed the drive");

    // input stalls only with both registers full and the result held
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_vld_reg && out_vld_reg && !m_tready))
        else $error("input stalled with room to move");

endmodule

`default_nettype wire

FILE: hw/rtl/lfpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// lfpd_cfg_regs: configuration register file
// takes one register write per request, indexed as listed in the package
// ----------------------------------------------------------------------------
`default_nettype none

module lfpd_cfg_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               wr_en,
    input  wire logic [lfpd_pkg::CFG_IDX_W-1:0]     wr_index,
    input  wire logic [lfpd_pkg::CFG_DATA_W-1:0]    wr_data,
    output lfpd_pkg::cfg_t                          cfg
);
    import lfpd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_POSITION_GAIN:   cfg_next.position_gain = $signed(wr_data[GAIN_W-1:0]);
                REG_DELTA_GAIN:      cfg_next.delta_gain = $signed(wr_data[GAIN_W-1:0]);
                REG_BLACK_THRESHOLD: cfg_next.black_threshold = wr_data[READ_W-1:0];
                REG_REFERENCE_POS:   cfg_next.reference_position = wr_data[POS_W-1:0];
                REG_MAX_CORRECTION:  cfg_next.max_correction = wr_data[SPEED_W-1:0];
                REG_SPEED_CEILING:   cfg_next.speed_ceiling = wr_data[SPEED_W-1:0];
                REG_SPEED_FLOOR:     cfg_next.speed_floor = wr_data[SPEED_W-1:0];
                REG_DEST_ADDRESS:    cfg_next.destination_address = wr_data[DEST_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // register file with reset values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.position_gain       <= 16'sd256;
            cfg_reg.delta_gain          <= 16'sd0;
            cfg_reg.black_threshold     <= 12'd2048;
            cfg_reg.reference_position  <= 13'd3500;
            cfg_reg.max_correction      <= 12'd4095;
            cfg_reg.speed_ceiling       <= 12'd4095;
            cfg_reg.speed_floor         <= 12'd0;
            cfg_reg.destination_address <= 16'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/lfpd_datapath.sv
// ----------------------------------------------------------------------------
// lfpd_datapath: single pass steering logic
// pd correction, wheel speed clamp, intersection check and park decision
// ----------------------------------------------------------------------------
`default_nettype none

module lfpd_datapath #(
    parameter int PARK_STEP = lfpd_pkg::PARK_STEP_DEFAULT
) (
    input  wire lfpd_pkg::sample_t              din,
    input  wire lfpd_pkg::cfg_t                 cfg,
    input  wire logic [lfpd_pkg::SPEED_W-1:0]   wheel_left,
    input  wire logic [lfpd_pkg::SPEED_W-1:0]   wheel_right,
    output lfpd_pkg::result_t                   dout
);
    import lfpd_pkg::*;

    localparam int ERR_W  = POS_W + 1;
    localparam int PROD_W = ERR_W + GAIN_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int PARK_W = $clog2(PARK_STEP + 1);
    localparam int DIST_W = ADDR_W + PARK_W;
    localparam int CMP_W  = (DIST_W > DEST_W) ? DIST_W : DEST_W;

    logic signed [ERR_W-1:0]  pos_err;
    logic signed [ERR_W-1:0]  pos_delta;
    logic signed [PROD_W-1:0] prod_err;
    logic signed [PROD_W-1:0] prod_delta;
    logic signed [SUM_W-1:0]  pd_sum;
    logic [SUM_W-1:0]         sum_abs;
    logic [CORR_W-1:0]        corr_mag;
    logic signed [CORR_W-1:0] corr_trunc;
    logic signed [CORR_W-1:0] corr_clip;
    logic signed [CORR_W:0]   right_raw;
    logic signed [CORR_W:0]   left_raw;
    logic [SPEED_W-1:0]       right_clamped;
    logic [SPEED_W-1:0]       left_clamped;
    logic [DIST_W-1:0]        park_dist;
    logic                     park;
    logic                     left_black;
    logic                     right_black;
    logic                     vtx_ok;
    logic                     hit;

    // position error and change
    assign pos_err   = $signed({1'b0, din.position}) - $signed({1'b0, cfg.reference_position});
    assign pos_delta = $signed({1'b0, din.position}) - $signed({1'b0, din.previous_position});

    // pd products (q22.8) and sum (q23.8) from q8.8 gains
    assign prod_err   = pos_err * cfg.position_gain;
    assign prod_delta = pos_delta * cfg.delta_gain;
    assign pd_sum     = SUM_W'(prod_err) + SUM_W'(prod_delta);

    // drop the fraction, rounding toward zero; magnitude stays below 2^21
    assign sum_abs    = pd_sum[SUM_W-1] ? SUM_W'(-pd_sum) : SUM_W'(pd_sum);
    assign corr_mag   = {1'b0, sum_abs[CORR_W+6:8]};
    assign corr_trunc = pd_sum[SUM_W-1] ? -$signed(corr_mag) : $signed(corr_mag);

    // upper clamp only
    assign corr_clip = (corr_trunc > $signed({{(CORR_W-SPEED_W){1'b0}}, cfg.max_correction}))
                     ? $signed({{(CORR_W-SPEED_W){1'b0}}, cfg.max_correction})
                     : corr_trunc;

    // steer the wheels
    assign right_raw = $signed({{(CORR_W+1-SPEED_W){1'b0}}, din.base_speed})
                     + $signed({corr_clip[CORR_W-1], corr_clip});
    assign left_raw  = $signed({{(CORR_W+1-SPEED_W){1'b0}}, din.base_speed})
                     - $signed({corr_clip[CORR_W-1], corr_clip});
    assign right_clamped = clamp_speed(right_raw, cfg.speed_ceiling, cfg.speed_floor);
    assign left_clamped  = clamp_speed(left_raw, cfg.speed_ceiling, cfg.speed_floor);

    // park once the distance passes the destination
    assign park_dist = DIST_W'(din.address_count) * DIST_W'(PARK_STEP);
    assign park      = CMP_W'(park_dist) > CMP_W'(cfg.destination_address);

    assign left_black  = din.left_reading > cfg.black_threshold;
    assign right_black = din.right_reading > cfg.black_threshold;

    // intersection rule per command
    always_comb begin
        vtx_ok = 1'b1;
        hit    = 1'b0;
        case (din.command)
            CMD_FORWARD: begin
                if (din.vertex_type == VTX_PLUS) begin
                    hit = left_black && right_black;
                end else if (din.vertex_type == VTX_LEFT_TEE) begin
                    hit = left_black;
                end else if (din.vertex_type == VTX_RIGHT_TEE) begin
                    hit = right_black;
                end else begin
                    vtx_ok = 1'b0;
                end
            end
            CMD_RIGHT: begin
                if (din.vertex_type == VTX_PLUS || din.vertex_type == VTX_TEE) begin
                    hit = left_black && right_black;
                end else if (din.vertex_type == VTX_RIGHT_TEE
                             || din.vertex_type == VTX_RIGHT_NINETY) begin
                    hit = right_black;
                end else begin
                    vtx_ok = 1'b0;
                end
            end
            CMD_LEFT: begin
                if (din.vertex_type == VTX_PLUS || din.vertex_type == VTX_TEE) begin
                    hit = left_black && right_black;
                end else if (din.vertex_type == VTX_LEFT_TEE
                             || din.vertex_type == VTX_LEFT_NINETY) begin
                    hit = left_black;
                end else begin
                    vtx_ok = 1'b0;
                end
            end
            default: begin
                vtx_ok = 1'b1;
                hit    = 1'b0;
            end
        endcase
    end

    // pick the result
    always_comb begin
        dout.correction  = corr_clip;
        dout.left_speed  = left_clamped;
        dout.right_speed = right_clamped;
        dout.status      = STAT_FOLLOW;
        if (din.command == CMD_ADDRESS) begin
            if (park) begin
                dout.correction  = '0;
                dout.left_speed  = wheel_left;
                dout.right_speed = wheel_right;
                dout.status      = STAT_PARK;
            end
        end else if (!vtx_ok) begin
            dout.correction  = '0;
            dout.left_speed  = '0;
            dout.right_speed = '0;
            dout.status      = STAT_EMERGENCY;
        end else if (hit) begin
            case (din.command)
                CMD_FORWARD: dout.status = STAT_CROSS;
                CMD_RIGHT:   dout.status = STAT_RIGHT;
                CMD_LEFT:    dout.status = STAT_LEFT;
                default:     dout.status = STAT_FOLLOW;
            endcase
        end
    end

endmodule

`default_nettype wire
